// ----- hdl/srt_pkg.sv -----
// srt_pkg: shared types and constants for the shortest-remaining-time scheduler
// item, result and table entry layouts; no dependencies
package srt_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int TIME_W        = 16;
  localparam int COUNT_W       = 5;
  localparam int SLOT_FIELD_W  = 4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [TIME_W-1:0]       arrival_time;
    logic [TIME_W-1:0]       burst_time;
  } item_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] chosen_slot;
    logic                    idle;
    logic                    all_done;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] remaining;
  } entry_t;

endpackage

// ----- hdl/srt_table.sv -----
// srt_table: process slot memory, one synchronous write port and one read port
// entries that were never loaded read back with zero remaining time; uses srt_pkg
module srt_table #(
  parameter int NUM_SLOTS = srt_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [$clog2(NUM_SLOTS)-1:0]   wr_addr,
  input  srt_pkg::entry_t                wr_data,
  input  logic [$clog2(NUM_SLOTS)-1:0]   rd_addr,
  output srt_pkg::entry_t                rd_data
);
  import srt_pkg::*;

  entry_t               mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid;
  entry_t               rd_q;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // per-entry written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  always_comb begin
    rd_data           = rd_q;
    rd_data.remaining = rd_valid ? rd_q.remaining : '0;
  end

  initial_unused_check: assert property (@(posedge clk) disable iff (rst)
      wr_en |=> valid[$past(wr_addr)])
    else $error("written entry not marked valid");

  unwritten_zero: assert property (@(posedge clk) disable iff (rst)
      !rd_valid |-> rd_data.remaining == '0)
    else $error("unwritten entry reads nonzero remaining time");

  read_tracks_flags: assert property (@(posedge clk) disable iff (rst)
      1'b1 |=> rd_valid == $past(valid[rd_addr]))
    else $error("read flag does not follow the written flags");

endmodule

// ----- hdl/srt_ctrl.sv -----
// srt_ctrl: tick sequencer, minimum search over the slot table and time counter
// reads one slot per cycle from srt_table and writes the winner back; uses srt_pkg
module srt_ctrl #(
  parameter int NUM_SLOTS = srt_pkg::NUM_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  srt_pkg::item_t                       item,
  input  logic                                 cfg_wr,
  input  logic [srt_pkg::COUNT_W-1:0]          cfg_data,
  output logic                                 done,
  output srt_pkg::result_t                     result,
  output logic                                 tbl_wr_en,
  output logic [$clog2(NUM_SLOTS)-1:0]         tbl_wr_addr,
  output srt_pkg::entry_t                      tbl_wr_data,
  output logic [$clog2(NUM_SLOTS)-1:0]         tbl_rd_addr,
  input  srt_pkg::entry_t                      tbl_rd_data
);
  import srt_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state;
  logic                 rd_pend;
  logic [TIME_W-1:0]    cur_time;
  logic [COUNT_W-1:0]   pcount;

  logic [CNT_W-1:0]     n_q;
  logic [CNT_W-1:0]     n_clamp;
  logic [CNT_W-1:0]     issue_cnt;
  logic [SLOT_W-1:0]    eval_addr;
  logic                 found;
  logic                 any_work;
  logic [SLOT_W-1:0]    best;
  logic [TIME_W-1:0]    best_rem;
  logic [TIME_W-1:0]    best_arr;

  logic                 load_acc;
  logic                 tick_acc;
  logic                 slot_ok;
  logic                 rd_en;
  logic                 finish;
  logic                 cand_work;
  logic                 cand_take;

  assign busy     = (state != ST_IDLE);
  assign load_acc = start && !busy && (item.kind == KIND_LOAD);
  assign tick_acc = start && !busy && (item.kind == KIND_TICK);
  assign slot_ok  = (32'(item.slot) < NUM_SLOTS);

  always_comb begin
    if (32'(pcount) > NUM_SLOTS) begin
      n_clamp = CNT_W'(NUM_SLOTS);
    end else begin
      n_clamp = CNT_W'(pcount);
    end
  end

  assign rd_en       = (state == ST_SCAN) && (issue_cnt < n_q);
  assign finish      = (state == ST_SCAN) && !(issue_cnt < n_q) && !rd_pend;
  assign tbl_rd_addr = issue_cnt[SLOT_W-1:0];

  // a load writes the whole entry; a tick writes back the winner
  always_comb begin
    tbl_wr_en = (load_acc && slot_ok) || (finish && found);
    if (finish) begin
      tbl_wr_addr           = best;
      tbl_wr_data.arrival   = best_arr;
      tbl_wr_data.remaining = best_rem - TIME_W'(1);
    end else begin
      tbl_wr_addr           = SLOT_W'(item.slot);
      tbl_wr_data.arrival   = item.arrival_time;
      tbl_wr_data.remaining = item.burst_time;
    end
  end

  assign cand_work = (tbl_rd_data.remaining != '0);
  assign cand_take = cand_work && (tbl_rd_data.arrival <= cur_time) &&
                     (!found || (tbl_rd_data.remaining < best_rem));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_pend  <= 1'b0;
      done     <= 1'b0;
      cur_time <= '0;
      pcount   <= '0;
    end else begin
      done    <= finish;
      rd_pend <= rd_en;
      if (cfg_wr) begin
        pcount <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (tick_acc) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (finish) begin
            state <= ST_IDLE;
            if (cur_time != '1) begin
              cur_time <= cur_time + TIME_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      n_q       <= n_clamp;
      issue_cnt <= '0;
      eval_addr <= '0;
      found     <= 1'b0;
      any_work  <= 1'b0;
      best      <= '0;
      best_rem  <= '0;
      best_arr  <= '0;
    end else begin
      if (rd_en) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      if (rd_pend) begin
        eval_addr <= eval_addr + SLOT_W'(1);
        if (cand_work) begin
          any_work <= 1'b1;
        end
        if (cand_take) begin
          found    <= 1'b1;
          best     <= eval_addr;
          best_rem <= tbl_rd_data.remaining;
          best_arr <= tbl_rd_data.arrival;
        end
      end
    end
    if (finish) begin
      result.chosen_slot <= found ? SLOT_FIELD_W'(best) : '0;
      result.idle        <= !found;
      result.all_done    <= !any_work;
    end
  end

  done_when_idle: assert property (@(posedge clk) disable iff (rst)
      done |-> !busy && $past(busy))
    else $error("result strobe outside the end of a tick");

  idle_slot_zero: assert property (@(posedge clk) disable iff (rst)
      (done && result.idle) |-> result.chosen_slot == '0)
    else $error("idle result carries a slot");

  all_done_idle: assert property (@(posedge clk) disable iff (rst)
      (done && result.all_done) |-> result.idle)
    else $error("all_done reported while a slot ran");

  time_saturates: assert property (@(posedge clk) disable iff (rst)
      (cur_time == '1) |=> (cur_time == '1))
    else $error("current time wrapped");

  no_write_mid_scan: assert property (@(posedge clk) disable iff (rst)
      (busy && !finish) |-> !tbl_wr_en)
    else $error("table written during a scan");

endmodule

// ----- hdl/shortest_remaining_time_scheduler_top.sv -----
// shortest_remaining_time_scheduler_top: load items give no result. a tick with
// n = min(process_count, NUM_SLOTS) slots in use reads the table one slot per cycle,
// then raises the done strobe; start is taken again the cycle done shows.
// done is never held off by the receiver. synchronous reset clears time, the slot count
// and every slot's remaining time at once; no clearing pass is needed.
module shortest_remaining_time_scheduler_top #(
  parameter int NUM_SLOTS = srt_pkg::NUM_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  srt_pkg::item_t              item,
  input  logic                        cfg_wr,
  input  logic [srt_pkg::COUNT_W-1:0] cfg_data,
  output logic                        done,
  output srt_pkg::result_t            result
);
  import srt_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);

  logic              tbl_wr_en;
  logic [SLOT_W-1:0] tbl_wr_addr;
  entry_t            tbl_wr_data;
  logic [SLOT_W-1:0] tbl_rd_addr;
  entry_t            tbl_rd_data;

  srt_ctrl #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .cfg_wr     (cfg_wr),
    .cfg_data   (cfg_data),
    .done       (done),
    .result     (result),
    .tbl_wr_en  (tbl_wr_en),
    .tbl_wr_addr(tbl_wr_addr),
    .tbl_wr_data(tbl_wr_data),
    .tbl_rd_addr(tbl_rd_addr),
    .tbl_rd_data(tbl_rd_data)
  );

  srt_table #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (tbl_wr_en),
    .wr_addr(tbl_wr_addr),
    .wr_data(tbl_wr_data),
    .rd_addr(tbl_rd_addr),
    .rd_data(tbl_rd_data)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// testbench: self-checking bench for shortest_remaining_time_scheduler_top
// drives load and tick transfers, predicts each scheduling pick; uses srt_pkg types
module testbench;
  import srt_pkg::*;

  localparam int SLOTS        = NUM_SLOTS_DEF;
  localparam int RANDOM_ITEMS = 1950;
  localparam int PHASES       = 8;
  localparam int SETTLE       = 24;
  localparam int SHOW_LIMIT   = 50;
  localparam int ITEM_W       = $bits(item_t);
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  item_t              item;
  logic               cfg_wr;
  logic [COUNT_W-1:0] cfg_data;
  logic               done;
  result_t            result;

  // scheduler mirror
  logic [TIME_W-1:0]  arrival_tbl [SLOTS];
  logic [TIME_W-1:0]  remain_tbl [SLOTS];
  logic [TIME_W-1:0]  sched_now;
  logic [COUNT_W-1:0] process_count_cfg;
  result_t            picks_due [$];
  int                 mismatch_count;
  bit                 use_gaps;

  shortest_remaining_time_scheduler_top dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_wr   (cfg_wr),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int slots_active();
    return (process_count_cfg > SLOTS) ? SLOTS : int'(process_count_cfg);
  endfunction

  // update the mirror for one accepted transfer, queue the pick a tick causes
  task automatic schedule_transfer(input item_t it);
    int                used;
    int                best;
    bit                found;
    bit                work_left;
    logic [TIME_W-1:0] best_rem;
    result_t           pick;
    if (it.kind == KIND_LOAD) begin
      arrival_tbl[it.slot] = it.arrival_time;
      remain_tbl[it.slot]  = it.burst_time;
    end else begin
      used      = slots_active();
      best      = 0;
      found     = 1'b0;
      work_left = 1'b0;
      best_rem  = '0;
      for (int i = 0; i < used; i++) begin
        if (remain_tbl[i] != 0) begin
          work_left = 1'b1;
          if (arrival_tbl[i] <= sched_now && (!found || remain_tbl[i] < best_rem)) begin
            found    = 1'b1;
            best     = i;
            best_rem = remain_tbl[i];
          end
        end
      end
      if (found) remain_tbl[best] = best_rem - 1'b1;
      if (sched_now != TIME_MAX) sched_now = sched_now + 1'b1;
      pick.chosen_slot = found ? best[SLOT_FIELD_W-1:0] : '0;
      pick.idle        = !found;
      pick.all_done    = !work_left;
      picks_due.push_back(pick);
    end
  endtask

  task automatic send_item(input item_t it);
    @(negedge clk);
    start = 1'b1;
    item  = it;
    @(posedge clk);
    while (busy) @(posedge clk);
    schedule_transfer(it);
  endtask

  task automatic load_slot(input int slot, input int arrival, input int burst);
    item_t it;
    it.kind         = KIND_LOAD;
    it.slot         = slot[SLOT_FIELD_W-1:0];
    it.arrival_time = arrival[TIME_W-1:0];
    it.burst_time   = burst[TIME_W-1:0];
    send_item(it);
  endtask

  // unused fields of a tick carry random bits
  task automatic tick();
    item_t it;
    it.kind         = KIND_TICK;
    it.slot         = SLOT_FIELD_W'($urandom);
    it.arrival_time = TIME_W'($urandom);
    it.burst_time   = TIME_W'($urandom);
    send_item(it);
  endtask

  task automatic pause();
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    if (!use_gaps || roll < 60) gap = 0;
    else if (roll < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // only written with the scheduler quiet: picks drained, trailing loads settled
  task automatic set_process_count(input int value);
    @(negedge clk);
    start = 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr   = 1'b1;
    cfg_data = value[COUNT_W-1:0];
    @(negedge clk);
    cfg_wr            = 1'b0;
    process_count_cfg = value[COUNT_W-1:0];
  endtask

  task automatic note_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (picks_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
          $display("%0t: result with none expected, got slot %0d idle %0b all_done %0b",
                   $time, result.chosen_slot, result.idle, result.all_done);
      end else begin
        want = picks_due.pop_front();
        if (result.chosen_slot !== want.chosen_slot)
          note_mismatch("chosen_slot", 8'(want.chosen_slot), 8'(result.chosen_slot));
        if (result.idle !== want.idle)
          note_mismatch("idle", 8'(want.idle), 8'(result.idle));
        if (result.all_done !== want.all_done)
          note_mismatch("all_done", 8'(want.all_done), 8'(result.all_done));
      end
    end
  end

  // no slots in use right after reset
  task automatic test_empty_table();
    tick();
  endtask

  // shortest first, ties to the lower slot, a late arrival holds work without running
  task automatic test_pick_order();
    for (int s = 0; s < SLOTS; s++) begin
      case (s)
        0, 5:    load_slot(s, 0, 2);
        9:       load_slot(s, 65535, 65535);
        15:      load_slot(s, 0, 1);
        default: load_slot(s, 0, 0);
      endcase
    end
    set_process_count(SLOTS);
    repeat (6) tick();
  endtask

  // a short window sees no work, a count past the table acts as the full table
  task automatic test_count_bounds();
    set_process_count(4);
    tick();
    set_process_count(31);
    tick();
  endtask

  task automatic test_random_mix();
    int plan [PHASES];
    int sent;
    int roll;
    int used;
    int slot;
    int arrival;
    int burst;
    int loads;
    int ticks;
    plan    = '{16, 1, 31, 0, 16, 2, 17, 9};
    plan[5] = $urandom_range(2, 15);
    plan[6] = $urandom_range(17, 30);
    plan[7] = $urandom_range(1, 16);
    for (int p = 0; p < PHASES; p++) begin
      set_process_count(plan[p]);
      use_gaps = ($urandom_range(0, 3) != 0);
      used     = slots_active();
      sent     = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        roll = $urandom_range(0, 99);
        if (roll < 72) begin
          // a few arrivals around the current time, then run the clock
          loads = $urandom_range(1, 4);
          for (int k = 0; k < loads; k++) begin
            if (used == 0 || $urandom_range(0, 9) == 0) slot = $urandom_range(0, SLOTS - 1);
            else slot = $urandom_range(0, used - 1);
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
              arrival = int'(sched_now) + $urandom_range(0, 5);
              if (arrival > 65535) arrival = 65535;
            end else if (roll < 90) arrival = $urandom_range(0, sched_now);
            else arrival = $urandom_range(0, 65535);
            roll = $urandom_range(0, 99);
            if (roll < 10) burst = 0;
            else if (roll < 90) burst = $urandom_range(1, 8);
            else if (roll < 95) burst = 65535;
            else burst = $urandom_range(0, 65535);
            load_slot(slot, arrival, burst);
            pause();
          end
          ticks = $urandom_range(1, 16);
          repeat (ticks) begin
            tick();
            pause();
          end
          sent += loads + ticks;
        end else if (roll < 80) begin
          // retire every slot in use so the table reports all done
          for (int s = 0; s < used; s++) begin
            load_slot(s, $urandom_range(0, 65535), 0);
            pause();
          end
          tick();
          pause();
          sent += used + 1;
        end else begin
          send_item(item_t'($urandom_range(0, 1) ? ITEM_W'({$urandom, $urandom})
                                                 : ITEM_W'($urandom)));
          pause();
          sent += 1;
        end
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    start             = 1'b0;
    item              = '0;
    cfg_wr            = 1'b0;
    cfg_data          = '0;
    sched_now         = '0;
    process_count_cfg = '0;
    mismatch_count    = 0;
    use_gaps          = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      arrival_tbl[s] = '0;
      remain_tbl[s]  = '0;
    end
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_pick_order();
    test_count_bounds();
    test_random_mix();

    @(negedge clk);
    start = 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && picks_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ----- shortest_remaining_time_scheduler_top.f -----
hdl/srt_pkg.sv
hdl/srt_table.sv
hdl/srt_ctrl.sv
hdl/shortest_remaining_time_scheduler_top.sv
tb/sv/testbench.sv
